>>> hdl/wrip_pkg.sv
// ----------------------------------------------------------------------------
// wrip_pkg: shared types and constants of the weighted random item picker
// Opcodes, result codes, sequencer states, bus widths and parameter defaults.
// ----------------------------------------------------------------------------
package wrip_pkg;

  localparam int NUM_RANKS_DEF        = 8;
  localparam int ENTRIES_PER_RANK_DEF = 16;
  localparam int ID_BITS_DEF          = 8;
  localparam int WEIGHT_BITS_DEF      = 16;

  localparam int RND_BITS    = 16;
  localparam int STEP_BITS   = $clog2(RND_BITS);
  localparam int S_DATA_BITS = 48;
  localparam int M_DATA_BITS = 16;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_ROLL,
    OP_EXCLUDE,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_RANK,
    STAT_DUP,
    STAT_FULL
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_SEARCH,
    ST_DONE
  } state_t;

endpackage

>>> hdl/weighted_random_item_picker.sv
// ----------------------------------------------------------------------------
// weighted_random_item_picker: roulette-wheel selection over ranked lists
// Per-rank lists of (id, weight) entries and a global exclusion bitmap.
// One shared adder sums weights, scales the random value and searches.
//
//   channel | dir | tdata                                   | tuser
//   s_      | in  | rank, item_id, weight, random_value     | operation
//   m_      | out | status, picked_id                       | item_valid
//
// Add and roll walk the list of their rank; roll then scales the weight sum by
// the random value and searches the list. The entry RAM's single read port and
// the shared adder visit one entry per cycle, the scaling takes one bit a cycle.
// The next request is taken in the cycle after the result is loaded. s_tready
// is high only between requests. Reset clears the list counts and the exclusion
// bitmap at once. A result waiting on m_tready holds the sequencer in its final
// state.
// ----------------------------------------------------------------------------
module weighted_random_item_picker #(
  parameter int NUM_RANKS        = wrip_pkg::NUM_RANKS_DEF,
  parameter int ENTRIES_PER_RANK = wrip_pkg::ENTRIES_PER_RANK_DEF,
  parameter int ID_BITS          = wrip_pkg::ID_BITS_DEF,
  parameter int WEIGHT_BITS      = wrip_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // rank[2:0], item_id[10:3], weight[26:11], random_value[42:27], zero pad
  input  logic [wrip_pkg::S_DATA_BITS-1:0]  s_tdata,
  // operation[1:0]
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status[1:0], picked_id[9:2], zero pad
  output logic [wrip_pkg::M_DATA_BITS-1:0]  m_tdata,
  // item_valid[0]
  output logic [0:0]                        m_tuser
);

  localparam int DEPTH      = NUM_RANKS * ENTRIES_PER_RANK;
  localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RANK_BITS  = (NUM_RANKS > 1) ? $clog2(NUM_RANKS) : 1;
  localparam int CNT_BITS   = $clog2(ENTRIES_PER_RANK + 1);
  localparam int SUM_BITS   = WEIGHT_BITS + CNT_BITS;
  localparam int MAP_SIZE   = 1 << ID_BITS;

  wrip_pkg::state_t  state, state_next;
  wrip_pkg::op_t     op_r;
  wrip_pkg::status_t res_status;

  logic [RANK_BITS-1:0]           rank_r;
  logic [ID_BITS-1:0]             id_r;
  logic [WEIGHT_BITS-1:0]         weight_r;
  logic [wrip_pkg::RND_BITS-1:0]  rnd_r;
  logic [ADDR_BITS-1:0]           base;
  logic [CNT_BITS-1:0]            cnt_r;
  logic [CNT_BITS-1:0]            ptr;
  logic                           rd_vld;
  logic [SUM_BITS-1:0]            acc;
  logic [SUM_BITS-1:0]            prod;
  logic [wrip_pkg::STEP_BITS-1:0] step;
  logic                           res_valid;
  logic [7:0]                     res_id;

  logic [CNT_BITS-1:0] counts [NUM_RANKS];
  logic [MAP_SIZE-1:0] excl_map;

  wrip_pkg::op_t          s_op;
  logic [2:0]             s_rank;
  logic [RANK_BITS+2:0]   s_rank_w;
  logic [RANK_BITS-1:0]   s_rank_idx;
  logic [ID_BITS-1:0]     s_id;
  logic [WEIGHT_BITS-1:0] s_weight;
  logic [wrip_pkg::RND_BITS-1:0] s_rnd;
  logic                   in_range;
  logic                   fire;
  logic                   list_op;

  logic [ID_BITS-1:0]     mem_id;
  logic [WEIGHT_BITS-1:0] mem_weight;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic                   wr_en;

  logic                   issue;
  logic                   walk_done;
  logic                   excl_hit;
  logic                   dup;
  logic                   hit;
  logic                   full;
  logic                   load_out;
  logic                   last_step;
  logic [SUM_BITS-1:0]    add_a;
  logic [SUM_BITS-1:0]    add_b;
  logic [SUM_BITS:0]      sum;

  assign s_op       = wrip_pkg::op_t'(s_tuser);
  assign s_rank     = s_tdata[2:0];
  assign s_rank_w   = (RANK_BITS + 3)'(s_rank);
  assign s_rank_idx = s_rank_w[RANK_BITS-1:0];
  assign s_id       = ID_BITS'(s_tdata[10:3]);
  assign s_weight   = WEIGHT_BITS'(s_tdata[26:11]);
  assign s_rnd      = s_tdata[42:27];
  assign in_range   = 32'(s_rank) < NUM_RANKS;
  assign list_op    = (s_op == wrip_pkg::OP_ADD) || (s_op == wrip_pkg::OP_ROLL);
  assign fire       = s_tvalid && s_tready;

  assign issue     = ptr < cnt_r;
  assign walk_done = !issue && !rd_vld;
  assign excl_hit  = excl_map[mem_id];
  assign full      = 32'(cnt_r) >= ENTRIES_PER_RANK;
  assign last_step = step == wrip_pkg::STEP_BITS'(wrip_pkg::RND_BITS - 1);
  assign rd_addr   = base + ADDR_BITS'(ptr);
  assign sum       = {1'b0, add_a} + {1'b0, add_b};

  assign dup = (state == wrip_pkg::ST_SCAN) && (op_r == wrip_pkg::OP_ADD) && rd_vld &&
               (mem_id == id_r);
  assign hit = (state == wrip_pkg::ST_SEARCH) && rd_vld && !excl_hit &&
               ({1'b0, prod} < sum);

  wrip_entry_ram #(
    .DEPTH       (DEPTH),
    .ADDR_BITS   (ADDR_BITS),
    .ID_BITS     (ID_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (base + ADDR_BITS'(cnt_r)),
    .wr_id     (id_r),
    .wr_weight (weight_r),
    .rd_addr   (rd_addr),
    .rd_id     (mem_id),
    .rd_weight (mem_weight)
  );

  always_comb begin
    state_next = state;
    case (state)
      wrip_pkg::ST_IDLE: begin
        if (fire) begin
          state_next = (list_op && in_range) ? wrip_pkg::ST_SCAN : wrip_pkg::ST_DONE;
        end
      end
      wrip_pkg::ST_SCAN: begin
        if (dup) begin
          state_next = wrip_pkg::ST_DONE;
        end else if (walk_done) begin
          if (op_r == wrip_pkg::OP_ROLL && acc != '0) begin
            state_next = wrip_pkg::ST_MUL;
          end else begin
            state_next = wrip_pkg::ST_DONE;
          end
        end
      end
      wrip_pkg::ST_MUL: begin
        if (last_step) begin
          state_next = wrip_pkg::ST_SEARCH;
        end
      end
      wrip_pkg::ST_SEARCH: begin
        if (hit || walk_done) begin
          state_next = wrip_pkg::ST_DONE;
        end
      end
      wrip_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = wrip_pkg::ST_IDLE;
        end
      end
      default: state_next = wrip_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    wr_en    = 1'b0;
    load_out = 1'b0;
    add_a    = acc;
    add_b    = SUM_BITS'(mem_weight);
    case (state)
      wrip_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      wrip_pkg::ST_SCAN: begin
        wr_en = (op_r == wrip_pkg::OP_ADD) && walk_done && !full;
      end
      wrip_pkg::ST_MUL: begin
        add_a = prod;
        add_b = rnd_r[0] ? acc : '0;
      end
      wrip_pkg::ST_SEARCH: begin
        add_a = acc;
      end
      wrip_pkg::ST_DONE: begin
        load_out = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= wrip_pkg::ST_IDLE;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
      excl_map <= '0;
      for (int r = 0; r < NUM_RANKS; r++) begin
        counts[r] <= '0;
      end
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        wrip_pkg::ST_IDLE: begin
          rd_vld <= 1'b0;
          if (fire && s_op == wrip_pkg::OP_EXCLUDE) begin
            excl_map[s_id] <= 1'b1;
          end
          if (fire && s_op == wrip_pkg::OP_CLEAR) begin
            excl_map <= '0;
          end
        end
        wrip_pkg::ST_SCAN, wrip_pkg::ST_SEARCH: begin
          rd_vld <= issue;
          if (wr_en) begin
            counts[rank_r] <= cnt_r + 1'b1;
          end
        end
        default: begin
          rd_vld <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {6'b0, res_id, res_status};
      m_tuser <= res_valid;
    end
    case (state)
      wrip_pkg::ST_IDLE: begin
        if (fire) begin
          op_r       <= s_op;
          rank_r     <= s_rank_idx;
          id_r       <= s_id;
          weight_r   <= s_weight;
          rnd_r      <= s_rnd;
          base       <= ADDR_BITS'(32'(s_rank) * ENTRIES_PER_RANK);
          cnt_r      <= in_range ? counts[s_rank_idx] : '0;
          ptr        <= '0;
          acc        <= '0;
          step       <= '0;
          res_valid  <= 1'b0;
          res_id     <= '0;
          res_status <= (list_op && !in_range) ? wrip_pkg::STAT_RANK : wrip_pkg::STAT_OK;
        end
      end
      wrip_pkg::ST_SCAN: begin
        if (issue) begin
          ptr <= ptr + 1'b1;
        end
        if (op_r == wrip_pkg::OP_ROLL && rd_vld && !excl_hit) begin
          acc <= sum[SUM_BITS-1:0];
        end
        if (dup) begin
          res_status <= wrip_pkg::STAT_DUP;
        end else if (op_r == wrip_pkg::OP_ADD && walk_done && full) begin
          res_status <= wrip_pkg::STAT_FULL;
        end
        prod <= '0;
      end
      wrip_pkg::ST_MUL: begin
        // drop the low product bit each step; the high half is the pick
        prod  <= sum[SUM_BITS:1];
        rnd_r <= rnd_r >> 1;
        step  <= step + 1'b1;
        if (last_step) begin
          acc <= '0;
          ptr <= '0;
        end
      end
      wrip_pkg::ST_SEARCH: begin
        if (issue) begin
          ptr <= ptr + 1'b1;
        end
        if (rd_vld && !excl_hit) begin
          acc <= sum[SUM_BITS-1:0];
        end
        if (hit) begin
          res_valid <= 1'b1;
          res_id    <= 8'(mem_id);
        end
      end
      default: begin
        step <= step;
      end
    endcase
  end

endmodule

>>> hdl/wrip_entry_ram.sv
// ----------------------------------------------------------------------------
// wrip_entry_ram: entry store of the item picker
// One write port and one read port; id and weight of each entry, read
// data registered.
// ----------------------------------------------------------------------------
module wrip_entry_ram #(
  parameter int DEPTH       = 128,
  parameter int ADDR_BITS   = 7,
  parameter int ID_BITS     = 8,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [ADDR_BITS-1:0]   wr_addr,
  input  logic [ID_BITS-1:0]     wr_id,
  input  logic [WEIGHT_BITS-1:0] wr_weight,
  input  logic [ADDR_BITS-1:0]   rd_addr,
  output logic [ID_BITS-1:0]     rd_id,
  output logic [WEIGHT_BITS-1:0] rd_weight
);

  logic [ID_BITS-1:0]     ids     [DEPTH];
  logic [WEIGHT_BITS-1:0] weights [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ids[wr_addr]     <= wr_id;
      weights[wr_addr] <= wr_weight;
    end
    rd_id     <= ids[rd_addr];
    rd_weight <= weights[rd_addr];
  end

endmodule

>>> hdl/wrip_checker.sv
// ----------------------------------------------------------------------------
// wrip_checker: port-level checks of the item picker
// Request spacing, result coding, output hold under stall and output after reset.
// ----------------------------------------------------------------------------
module wrip_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [wrip_pkg::S_DATA_BITS-1:0] s_tdata,
  input logic [1:0]                       s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [wrip_pkg::M_DATA_BITS-1:0] m_tdata,
  input logic [0:0]                       m_tuser
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while previous one in progress");

  a_item_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[1:0] == wrip_pkg::STAT_OK)
    else $error("picked item with non-ok status");

  a_no_item_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[9:2] == 8'd0)
    else $error("picked id nonzero without item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind weighted_random_item_picker wrip_checker u_wrip_checker (.*);
